FILE: rtl/tunnel_record_deframer_assert.svh
// ----------------------------------------------------------------------------
// tunnel record deframer assertion macros
// shared checks, clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef TUNNEL_RECORD_DEFRAMER_ASSERT_SVH
`define TUNNEL_RECORD_DEFRAMER_ASSERT_SVH

// condition holds at every edge out of reset
`define TRD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the tunnel record deframer
// ----------------------------------------------------------------------------
package trd_pkg;

    // record framing
    localparam logic [7:0]  LabelByte   = 8'h10;
    localparam int          HeaderBytes = 6;
    localparam logic [15:0] CapReset    = 16'd2008;

    // command queue between front and back (depth a power of two)
    localparam int QueueDepth = 8;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // result kind carried on tuser
    typedef enum logic [1:0] {
        ST_RECORD   = 2'd0,
        ST_BADLABEL = 2'd1,
        ST_OVERSIZE = 2'd2
    } trd_status_t;

    // one queued command: either a single result word or a six-byte header
    // data holds {length, type} for a header, the payload byte in the low bits for a payload word, zero otherwise
    typedef struct packed {
        logic        hdr;
        logic        last;
        trd_status_t status;
        logic [47:0] data;
    } trd_entry_t;

    // front to queue
    typedef struct packed {
        logic       valid;
        trd_entry_t entry;
    } trd_push_t;

    // queue to back
    typedef struct packed {
        logic       valid;
        trd_entry_t entry;
    } trd_head_t;

endpackage

FILE: rtl/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front
// label hunt, header collection and capacity check; queues one command per
// result-bearing input word
// ----------------------------------------------------------------------------
module trd_front import trd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,    // [15:0] output_capacity
    input  logic        q_full,
    output trd_push_t   push
);

    typedef enum logic [4:0] {
        PH_HUNT0   = 5'b00001,
        PH_HUNT1   = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_SKIP    = 5'b10000
    } trd_phase_t;

    trd_phase_t  phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [15:0] type_reg, type_next;
    logic [23:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] cap_reg;

    logic        accept;
    logic [31:0] len_full;
    logic [32:0] total;
    logic        oversize;
    logic [31:0] rem_dec;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CapReset;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // capacity check on the full header
    assign len_full = {s_tdata, len_reg};
    assign total    = {1'b0, len_full} + 33'(HeaderBytes);
    assign oversize = total > {17'b0, cap_reg};
    assign rem_dec  = (rem_reg == 32'd0) ? 32'd0 : rem_reg - 32'd1;

    // parser
    always_comb begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        push       = '0;
        if (accept) begin
            case (phase_reg)
                PH_HUNT1: begin
                    if (s_tdata == LabelByte) begin
                        phase_next = PH_HEADER;
                        hpos_next  = 3'd0;
                    end else begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_BADLABEL;
                        push.entry.last   = 1'b1;
                        phase_next        = PH_HUNT0;
                    end
                end
                PH_HEADER: begin
                    hpos_next = hpos_reg + 3'd1;
                    case (hpos_reg)
                        3'd0: type_next[7:0]   = s_tdata;
                        3'd1: type_next[15:8]  = s_tdata;
                        3'd2: len_next[7:0]    = s_tdata;
                        3'd3: len_next[15:8]   = s_tdata;
                        3'd4: len_next[23:16]  = s_tdata;
                        default: begin
                            // last length byte: decide the record
                            hpos_next   = 3'd0;
                            rem_next    = len_full;
                            push.valid  = 1'b1;
                            if (oversize) begin
                                push.entry.status = ST_OVERSIZE;
                                push.entry.last   = 1'b1;
                                phase_next = (len_full == 32'd0) ? PH_HUNT0 : PH_SKIP;
                            end else begin
                                push.entry.hdr    = 1'b1;
                                push.entry.status = ST_RECORD;
                                push.entry.last   = (len_full == 32'd0);
                                push.entry.data   = {len_full, type_reg};
                                phase_next = (len_full == 32'd0) ? PH_HUNT0 : PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                PH_PAYLOAD: begin
                    rem_next          = rem_dec;
                    push.valid        = 1'b1;
                    push.entry.status = ST_RECORD;
                    push.entry.last   = (rem_dec == 32'd0);
                    push.entry.data   = {40'b0, s_tdata};
                    if (rem_dec == 32'd0) begin
                        phase_next = PH_HUNT0;
                    end
                end
                PH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) begin
                        phase_next = PH_HUNT0;
                    end
                end
                default: begin
                    // hunting for the first label byte
                    if (s_tdata == LabelByte) begin
                        phase_next = PH_HUNT1;
                    end else begin
                        push.valid        = 1'b1;
                        push.entry.status = ST_BADLABEL;
                        push.entry.last   = 1'b1;
                        phase_next        = PH_HUNT0;
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT0;
            hpos_reg  <= 3'd0;
            rem_reg   <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            rem_reg   <= rem_next;
        end
    end

    // header bytes collected so far
    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        len_reg  <= len_next;
    end

endmodule

FILE: rtl/trd_queue.sv
// ----------------------------------------------------------------------------
// trd_queue
// short command queue between the parser and the output side
// ----------------------------------------------------------------------------
`include "tunnel_record_deframer_assert.svh"

module trd_queue import trd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  trd_push_t push,
    output logic      full,
    output trd_head_t head,
    input  logic      pop
);

    trd_entry_t             entry_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QueueCntW-1:0]   count_reg, count_next;

    assign full       = (count_reg == QueueCntW'(QueueDepth));
    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers wrap on their own width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `TRD_ASSERT_ALWAYS(a_no_push_full, !(push.valid && full), "push into full queue")
    `TRD_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !head.valid), "pop from empty queue")
    `TRD_ASSERT_NEXT(a_count_up, push.valid && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

FILE: rtl/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back
// expands queued commands into result words and holds the output register
// ----------------------------------------------------------------------------
`include "tunnel_record_deframer_assert.svh"

module trd_back import trd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  trd_head_t  head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast    // last
);

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    trd_status_t m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    logic        busy_reg, busy_next;
    logic [2:0]  pos_reg, pos_next;
    logic [47:0] hdr_data_reg, hdr_data_next;
    logic        hdr_last_reg, hdr_last_next;

    logic        load;
    logic [7:0]  hdr_byte;

    // header byte at the current position
    always_comb begin
        case (pos_reg)
            3'd0:    hdr_byte = hdr_data_reg[7:0];
            3'd1:    hdr_byte = hdr_data_reg[15:8];
            3'd2:    hdr_byte = hdr_data_reg[23:16];
            3'd3:    hdr_byte = hdr_data_reg[31:24];
            3'd4:    hdr_byte = hdr_data_reg[39:32];
            default: hdr_byte = hdr_data_reg[47:40];
        endcase
    end

    assign load = !m_valid_reg || m_tready;

    // next word: continue a header or take the queue head
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        busy_next     = busy_reg;
        pos_next      = pos_reg;
        hdr_data_next = hdr_data_reg;
        hdr_last_next = hdr_last_reg;
        pop           = 1'b0;
        if (load) begin
            m_valid_next = 1'b0;
            if (busy_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = hdr_byte;
                m_user_next  = ST_RECORD;
                m_last_next  = (pos_reg == 3'(HeaderBytes - 1)) && hdr_last_reg;
                pos_next     = pos_reg + 3'd1;
                busy_next    = (pos_reg != 3'(HeaderBytes - 1));
            end else if (head.valid) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                m_data_next  = head.entry.data[7:0];
                m_user_next  = head.entry.status;
                if (head.entry.hdr) begin
                    m_last_next   = 1'b0;
                    busy_next     = 1'b1;
                    pos_next      = 3'd1;
                    hdr_data_next = head.entry.data;
                    hdr_last_next = head.entry.last;
                end else begin
                    m_last_next = head.entry.last;
                end
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            busy_reg    <= 1'b0;
            pos_reg     <= 3'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
        hdr_data_reg <= hdr_data_next;
        hdr_last_reg <= hdr_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `TRD_ASSERT_ALWAYS(a_pos_range, !busy_reg || ((pos_reg != 3'd0) && (pos_reg < 3'(HeaderBytes))), "header position out of range")

endmodule

FILE: rtl/tunnel_record_deframer.sv
// ----------------------------------------------------------------------------
// tunnel_record_deframer
// strips labels from a byte stream of tunnel records and forwards type,
// length and payload, flagging bad labels and oversize records
//
//   channel  direction  handshake            contents
//   s_       in         s_tvalid / s_tready  tdata[7:0] data_byte
//   m_       out        m_tvalid / m_tready  tdata[7:0] out_byte,
//                                            tuser[1:0] status, tlast last
//   cfg_     in         cfg_valid/cfg_ready  cfg_data[15:0] output_capacity
//
// one input word per cycle while s_tready is high; a header becomes six output
// words in the output stage, absorbed by the eight-entry command queue
// the queue slot is written when the input word is accepted; the output register
// loads from the queue head when it is free and no header is being expanded
// s_tready falls only when the command queue is full; cfg_ready is always high
// aresetn is synchronous; it clears parser, queue and output state and
// restores the capacity to 2008
// ----------------------------------------------------------------------------
module tunnel_record_deframer import trd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // [15:0] output_capacity
);

    trd_push_t push;
    trd_head_t head;
    logic      q_full;
    logic      pop;

    // parser
    trd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push)
    );

    // command queue
    trd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    // output side
    trd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
